/* sv/uvs_pkg.sv */
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types, register codes and fixed-point helpers of the uv sphere
// vertex generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

   // field and port widths
   localparam int INDEX_W    = 8;
   localparam int GRID_W     = 9;
   localparam int RADIUS_W   = 16;
   localparam int POS_W      = 17;
   localparam int NORM_W     = 16;
   localparam int VERT_W     = 16;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 168;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   // grid limits and register reset values
   localparam logic [GRID_W-1:0]   MAX_GRID        = 9'd256;
   localparam logic [GRID_W-1:0]   MIN_ROWS        = 9'd3;
   localparam logic [GRID_W-1:0]   MIN_COLS        = 9'd4;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET    = 16'd256;
   localparam logic [GRID_W-1:0]   LAT_LINES_RESET = 9'd16;
   localparam logic [GRID_W-1:0]   LON_LINES_RESET = 9'd16;

   // register indexes of the configuration port
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_RADIUS    = 2'd0,
      REG_LAT_LINES = 2'd1,
      REG_LON_LINES = 2'd2
   } csr_index_type;

   // cordic constants: 1/gain in Q2.30, arctangents in 2^-32 turns
   localparam int CORDIC_STEPS = 24;
   localparam logic signed [33:0] CORDIC_X0 = 34'sd652032875;
   localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004757,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   // quad indices that travel beside the geometry
   typedef struct packed {
      logic [VERT_W-1:0] here;
      logic [VERT_W-1:0] east;
      logic [VERT_W-1:0] south_east;
      logic [VERT_W-1:0] south;
      logic              quad_valid;
   } vert_type;

   // one result item
   typedef struct packed {
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  pos_z;
      logic signed [NORM_W-1:0] norm_x;
      logic signed [NORM_W-1:0] norm_y;
      logic signed [NORM_W-1:0] norm_z;
      vert_type                 vert;
   } rsp_item_type;

   // round half up by 15 bits and saturate to q1.15
   function automatic logic signed [NORM_W-1:0] round_q15(input logic signed [35:0] v);
      logic signed [35:0] t;
      t = (v + 36'sd16384) >>> 15;
      if (t > 36'sd32767) begin
         return 16'sh7fff;
      end else if (t < -36'sd32768) begin
         return 16'sh8000;
      end
      return t[NORM_W-1:0];
   endfunction

   // round half up by 15 bits and saturate to +-65535
   function automatic logic signed [POS_W-1:0] round_pos(input logic signed [33:0] v);
      logic signed [33:0] t;
      t = (v + 34'sd16384) >>> 15;
      if (t > 34'sd65535) begin
         return 17'sd65535;
      end else if (t < -34'sd65535) begin
         return -17'sd65535;
      end
      return t[POS_W-1:0];
   endfunction

endpackage

/* sv/uv_sphere_vertex_generator.sv */
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// pipeline: the column modulo, the two-bit-per-stage angle dividers and the
//   24-iteration cordic, two steps per stage
// throughput: one item per cycle while rsp_tready stays high; a held result
//   fills the skid entry and req_tready drops until that entry drains
// reset: synchronous, clears all valid bits and loads the register defaults
// ----------------------------------------------------------------------------
// Generates the normal, position and quad indices of one uv sphere grid point.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // input items
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [uvs_pkg::REQ_DATA_W-1:0]      req_tdata,   // lat_index, lon_index
   // result items
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, vert_here, vert_east,
   // vert_south_east, vert_south, quad_valid, zero fill
   output logic [uvs_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // configuration writes
   input  logic                                csr_wen,
   input  logic [uvs_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [uvs_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int MOD_LAT = (uvs_pkg::INDEX_W + 1) / 2;
   localparam int DNUM_W  = ANGLE_BITS + 9;
   localparam int DIV_LAT = (DNUM_W + 1) / 2;
   localparam int COS_LAT = uvs_pkg::CORDIC_STEPS / 2 + 1;
   localparam int VD      = DIV_LAT + COS_LAT + 3;
   localparam int NS      = MOD_LAT + DIV_LAT + COS_LAT + 6;

   // configuration registers
   logic [uvs_pkg::RADIUS_W-1:0] radius_ff;
   logic [uvs_pkg::GRID_W-1:0]   lat_lines_ff;
   logic [uvs_pkg::GRID_W-1:0]   lon_lines_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= uvs_pkg::RADIUS_RESET;
         lat_lines_ff <= uvs_pkg::LAT_LINES_RESET;
         lon_lines_ff <= uvs_pkg::LON_LINES_RESET;
      end else if (csr_wen) begin
         case (uvs_pkg::csr_index_type'(csr_addr))
            uvs_pkg::REG_RADIUS:    radius_ff    <= csr_wdata;
            uvs_pkg::REG_LAT_LINES: lat_lines_ff <= csr_wdata[uvs_pkg::GRID_W-1:0];
            uvs_pkg::REG_LON_LINES: lon_lines_ff <= csr_wdata[uvs_pkg::GRID_W-1:0];
            default: ;
         endcase
      end
   end

   // clamped grid sizes
   logic [uvs_pkg::GRID_W-1:0]   rows_in, rows_ff;
   logic [uvs_pkg::GRID_W-1:0]   cols_in, cols_ff;
   logic [uvs_pkg::INDEX_W-1:0]  den_in, den_ff;

   always_comb begin
      if (lat_lines_ff < uvs_pkg::MIN_ROWS) begin
         rows_in = uvs_pkg::MIN_ROWS;
      end else if (lat_lines_ff > uvs_pkg::MAX_GRID) begin
         rows_in = uvs_pkg::MAX_GRID;
      end else begin
         rows_in = lat_lines_ff;
      end
      if (lon_lines_ff < uvs_pkg::MIN_COLS) begin
         cols_in = uvs_pkg::MIN_COLS;
      end else if (lon_lines_ff > uvs_pkg::MAX_GRID) begin
         cols_in = uvs_pkg::MAX_GRID;
      end else begin
         cols_in = lon_lines_ff;
      end
      den_in = uvs_pkg::INDEX_W'(rows_in - 9'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= uvs_pkg::LAT_LINES_RESET;
         cols_ff <= uvs_pkg::LON_LINES_RESET;
         den_ff  <= uvs_pkg::INDEX_W'(uvs_pkg::LAT_LINES_RESET - 9'd1);
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
         den_ff  <= den_in;
      end
   end

   // pipeline control: all stages advance unless the output buffer is full
   logic          en;
   logic [NS-1:0] valid_ff;
   logic          skid_valid_ff;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NS-2:0], req_tvalid};
      end
   end

   // input stage
   logic [uvs_pkg::INDEX_W-1:0] lat_ff;
   logic [uvs_pkg::INDEX_W-1:0] lon_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         lat_ff <= req_tdata[7:0];
         lon_ff <= req_tdata[15:8];
      end
   end

   // column modulo the column count, row travels beside it
   logic [uvs_pkg::GRID_W-1:0]  mod_rem;
   logic [uvs_pkg::INDEX_W-1:0] row_dly_ff [MOD_LAT];

   uvs_div #(
      .NUM_W           (uvs_pkg::INDEX_W),
      .DEN_W           (uvs_pkg::GRID_W),
      .QUO_W           (2),
      .STEPS_PER_STAGE (2)
   ) u_col_mod (
      .clock (clock),
      .en    (en),
      .num   (lon_ff),
      .den   (cols_ff),
      .quo   (),
      .rem   (mod_rem)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         row_dly_ff[0] <= lat_ff;
         for (int i = 1; i < MOD_LAT; i++) begin
            row_dly_ff[i] <= row_dly_ff[i-1];
         end
      end
   end

   // angle dividends and quad indices
   logic [uvs_pkg::INDEX_W-1:0] row;
   logic [uvs_pkg::INDEX_W-1:0] col;
   logic [uvs_pkg::INDEX_W-1:0] next_col;
   logic [16:0]                 base;
   logic [16:0]                 base_s;
   logic                        qv;
   logic [DNUM_W-1:0]           pol_num_in, pol_num_ff;
   logic [DNUM_W-1:0]           azi_num_in, azi_num_ff;
   logic [9:0]                  pol_den_ff;
   logic [9:0]                  azi_den_ff;
   uvs_pkg::vert_type           vert_in, vert_ff;

   always_comb begin
      row      = row_dly_ff[MOD_LAT-1];
      col      = mod_rem[uvs_pkg::INDEX_W-1:0];
      next_col = ({1'b0, col} + 9'd1 == cols_ff) ? '0 : col + 8'd1;
      base     = 17'(row) * 17'(cols_ff);
      base_s   = base + 17'(cols_ff);
      qv       = ({1'b0, row} + 9'd1) < rows_ff;
      pol_num_in = {1'b0, row, ANGLE_BITS'(den_ff)};
      azi_num_in = {col, (ANGLE_BITS + 1)'(cols_ff)};
      vert_in.here       = uvs_pkg::VERT_W'(base + 17'(col));
      vert_in.east       = qv ? uvs_pkg::VERT_W'(base + 17'(next_col)) : '0;
      vert_in.south_east = qv ? uvs_pkg::VERT_W'(base_s + 17'(next_col)) : '0;
      vert_in.south      = qv ? uvs_pkg::VERT_W'(base_s + 17'(col)) : '0;
      vert_in.quad_valid = qv;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pol_num_ff <= pol_num_in;
         azi_num_ff <= azi_num_in;
         pol_den_ff <= {1'b0, den_ff, 1'b0};
         azi_den_ff <= {cols_ff, 1'b0};
         vert_ff    <= vert_in;
      end
   end

   // polar and azimuth turn angles
   logic [ANGLE_BITS-1:0] polar;
   logic [ANGLE_BITS-1:0] azim;

   uvs_div #(
      .NUM_W           (DNUM_W),
      .DEN_W           (10),
      .QUO_W           (ANGLE_BITS),
      .STEPS_PER_STAGE (2)
   ) u_polar_div (
      .clock (clock),
      .en    (en),
      .num   (pol_num_ff),
      .den   (pol_den_ff),
      .quo   (polar),
      .rem   ()
   );

   uvs_div #(
      .NUM_W           (DNUM_W),
      .DEN_W           (10),
      .QUO_W           (ANGLE_BITS),
      .STEPS_PER_STAGE (2)
   ) u_azim_div (
      .clock (clock),
      .en    (en),
      .num   (azi_num_ff),
      .den   (azi_den_ff),
      .quo   (azim),
      .rem   ()
   );

   // sine and cosine of both angles
   logic signed [15:0] ct, st, cp, sp;

   uvs_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_polar_cordic (
      .clock   (clock),
      .en      (en),
      .angle   (polar),
      .cos_q15 (ct),
      .sin_q15 (st)
   );

   uvs_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_azim_cordic (
      .clock   (clock),
      .en      (en),
      .angle   (azim),
      .cos_q15 (cp),
      .sin_q15 (sp)
   );

   // quad indices ride along to the last stage
   uvs_pkg::vert_type vd_ff [VD];

   always_ff @(posedge clock) begin
      if (en) begin
         vd_ff[0] <= vert_ff;
         for (int i = 1; i < VD; i++) begin
            vd_ff[i] <= vd_ff[i-1];
         end
      end
   end

   // normal products, rounding, radius products, position rounding
   logic signed [31:0] px_ff, pz_ff;
   logic signed [15:0] ct_ff;
   logic signed [15:0] nx_ff, ny_ff, nz_ff;
   logic signed [32:0] rx_ff, ry_ff, rz_ff;
   logic signed [15:0] nxr_ff, nyr_ff, nzr_ff;
   logic signed [16:0] rad_s;
   uvs_pkg::rsp_item_type pos_in, pos_ff;

   assign rad_s = $signed({1'b0, radius_ff});

   always_comb begin
      pos_in.pos_x  = uvs_pkg::round_pos(34'(rx_ff));
      pos_in.pos_y  = uvs_pkg::round_pos(34'(ry_ff));
      pos_in.pos_z  = uvs_pkg::round_pos(34'(rz_ff));
      pos_in.norm_x = nxr_ff;
      pos_in.norm_y = nyr_ff;
      pos_in.norm_z = nzr_ff;
      pos_in.vert   = vd_ff[VD-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff  <= sp * st;
         pz_ff  <= cp * st;
         ct_ff  <= ct;
         nx_ff  <= uvs_pkg::round_q15(36'(px_ff));
         nz_ff  <= uvs_pkg::round_q15(36'(pz_ff));
         ny_ff  <= ct_ff;
         rx_ff  <= rad_s * nx_ff;
         ry_ff  <= rad_s * ny_ff;
         rz_ff  <= rad_s * nz_ff;
         nxr_ff <= nx_ff;
         nyr_ff <= ny_ff;
         nzr_ff <= nz_ff;
         pos_ff <= pos_in;
      end
   end

   // output register plus skid entry
   logic                  take;
   logic                  pipe_out;
   logic                  out_valid_ff;
   uvs_pkg::rsp_item_type out_ff;
   uvs_pkg::rsp_item_type skid_ff;

   assign take     = out_valid_ff && rsp_tready;
   assign pipe_out = en && valid_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (pipe_out) begin
         if (!out_valid_ff || take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (pipe_out) begin
         if (!out_valid_ff || take) begin
            out_ff <= pos_ff;
         end else begin
            skid_ff <= pos_ff;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000,
                        out_ff.vert.quad_valid,
                        out_ff.vert.south,
                        out_ff.vert.south_east,
                        out_ff.vert.east,
                        out_ff.vert.here,
                        out_ff.norm_z,
                        out_ff.norm_y,
                        out_ff.norm_x,
                        out_ff.pos_z,
                        out_ff.pos_y,
                        out_ff.pos_x};

endmodule

/* sv/uvs_div.sv */
// ----------------------------------------------------------------------------
// uvs_div
// Pipelined restoring divider, a fixed number of quotient bits per stage.
// Gives the low quotient bits and the remainder.
// ----------------------------------------------------------------------------
module uvs_div #(
   parameter int NUM_W           = 25,
   parameter int DEN_W           = 10,
   parameter int QUO_W           = 16,
   parameter int STEPS_PER_STAGE = 2
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo,
   output logic [DEN_W-1:0] rem
);

   localparam int STAGES = (NUM_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int NP     = STAGES * STEPS_PER_STAGE;

   logic [NP-1:0]    n_in  [STAGES];
   logic [NP-1:0]    n_ff  [STAGES];
   logic [DEN_W-1:0] r_in  [STAGES];
   logic [DEN_W-1:0] r_ff  [STAGES];
   logic [QUO_W-1:0] q_in  [STAGES];
   logic [QUO_W-1:0] q_ff  [STAGES];
   logic [DEN_W-1:0] d_ff  [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic [NP-1:0]    ns;
      logic [DEN_W-1:0] rs;
      logic [QUO_W-1:0] qs;
      logic [DEN_W-1:0] ds;

      if (k == 0) begin : g_first
         assign ns = NP'(num);
         assign rs = '0;
         assign qs = '0;
         assign ds = den;
      end else begin : g_next
         assign ns = n_ff[k-1];
         assign rs = r_ff[k-1];
         assign qs = q_ff[k-1];
         assign ds = d_ff[k-1];
      end

      // shift in one dividend bit, subtract when it fits
      always_comb begin
         logic [DEN_W:0] t;
         logic           qb;
         n_in[k] = ns;
         r_in[k] = rs;
         q_in[k] = qs;
         for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            t = {r_in[k], n_in[k][NP-1]};
            n_in[k] = n_in[k] << 1;
            qb = (t >= {1'b0, ds});
            if (qb) begin
               t = t - {1'b0, ds};
            end
            r_in[k] = t[DEN_W-1:0];
            q_in[k] = {q_in[k][QUO_W-2:0], qb};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k] <= n_in[k];
            r_ff[k] <= r_in[k];
            q_ff[k] <= q_in[k];
            d_ff[k] <= ds;
         end
      end
   end

   assign quo = q_ff[STAGES-1];
   assign rem = r_ff[STAGES-1];

endmodule

/* sv/uvs_cordic.sv */
// ----------------------------------------------------------------------------
// uvs_cordic
// Pipelined rotation-mode cordic for a turn angle, two iterations per stage,
// then quadrant folding and rounding to q1.15 cosine and sine.
// ----------------------------------------------------------------------------
module uvs_cordic #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [ANGLE_BITS-1:0]  angle,
   output logic signed [15:0]     cos_q15,
   output logic signed [15:0]     sin_q15
);

   localparam int SPS    = 2;
   localparam int STAGES = uvs_pkg::CORDIC_STEPS / SPS;

   logic signed [33:0] x_in [STAGES];
   logic signed [33:0] x_ff [STAGES];
   logic signed [33:0] y_in [STAGES];
   logic signed [33:0] y_ff [STAGES];
   logic signed [32:0] z_in [STAGES];
   logic signed [32:0] z_ff [STAGES];
   logic [1:0]         quad_ff [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic signed [33:0] xs;
      logic signed [33:0] ys;
      logic signed [32:0] zs;
      logic [1:0]         qs;

      if (k == 0) begin : g_first
         assign xs = uvs_pkg::CORDIC_X0;
         assign ys = '0;
         assign zs = $signed({3'b000, angle[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}});
         assign qs = angle[ANGLE_BITS-1:ANGLE_BITS-2];
      end else begin : g_next
         assign xs = x_ff[k-1];
         assign ys = y_ff[k-1];
         assign zs = z_ff[k-1];
         assign qs = quad_ff[k-1];
      end

      // micro-rotations toward zero residual angle
      always_comb begin
         logic signed [33:0] dx;
         logic signed [33:0] dy;
         logic signed [32:0] at;
         x_in[k] = xs;
         y_in[k] = ys;
         z_in[k] = zs;
         for (int j = 0; j < SPS; j++) begin
            dx = y_in[k] >>> (k * SPS + j);
            dy = x_in[k] >>> (k * SPS + j);
            at = $signed({1'b0, uvs_pkg::ATAN_TURNS[k * SPS + j]});
            if (!z_in[k][32]) begin
               x_in[k] = x_in[k] - dx;
               y_in[k] = y_in[k] + dy;
               z_in[k] = z_in[k] - at;
            end else begin
               x_in[k] = x_in[k] + dx;
               y_in[k] = y_in[k] - dy;
               z_in[k] = z_in[k] + at;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k]    <= x_in[k];
            y_ff[k]    <= y_in[k];
            z_ff[k]    <= z_in[k];
            quad_ff[k] <= qs;
         end
      end
   end

   // quadrant folding and rounding
   logic signed [33:0] cr;
   logic signed [33:0] sr;
   logic signed [15:0] cos_in, cos_ff;
   logic signed [15:0] sin_in, sin_ff;

   always_comb begin
      case (quad_ff[STAGES-1])
         2'd0: begin
            cr = x_ff[STAGES-1];
            sr = y_ff[STAGES-1];
         end
         2'd1: begin
            cr = -y_ff[STAGES-1];
            sr = x_ff[STAGES-1];
         end
         2'd2: begin
            cr = -x_ff[STAGES-1];
            sr = -y_ff[STAGES-1];
         end
         default: begin
            cr = y_ff[STAGES-1];
            sr = -x_ff[STAGES-1];
         end
      endcase
      cos_in = uvs_pkg::round_q15(36'(cr));
      sin_in = uvs_pkg::round_q15(36'(sr));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_q15 = cos_ff;
   assign sin_q15 = sin_ff;

endmodule
